FILE: rtl/s2c_pkg.sv
// Shared types, constants and the arctangent table for the spherical to
// Cartesian converter. No dependencies; used by every module in rtl/.
package s2c_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam int FIELD_W    = 16;
    localparam int OUT_W      = 17;
    localparam int PHASE_W    = 32;
    localparam int DATA_W     = 36;
    localparam int RES_W      = 34;
    localparam int STEP_IDX_W = 5;
    localparam int GAIN_W     = 30;
    localparam int RAD_PROD_W = FIELD_W + GAIN_W;
    localparam int C_W        = 34;
    localparam int C_PROD_W   = C_W + GAIN_W + 1;
    localparam int RND_W      = DATA_W - 16;

    // Limit gain 1/1.6468 in Q30.
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam logic signed [RND_W-1:0] OUT_MAX = 20'sd65535;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [RES_W-1:0]  res_t;

    typedef struct packed {
        data_t x;
        data_t y;
        res_t  z;
        logic  flip;
        data_t aux;
    } cordic_t;

    // atan(2^-i) in units of 2^32 per turn.
    function automatic logic [PHASE_W-1:0] atan_phase(input logic [STEP_IDX_W-1:0] idx);
        logic [PHASE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/s2c_cordic_cell.sv
// One CORDIC rotation step with its own pipeline register and handshake.
// Depends on s2c_pkg for the data struct and the arctangent table.
module s2c_cordic_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [s2c_pkg::STEP_IDX_W-1:0] step_idx,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  s2c_pkg::cordic_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output s2c_pkg::cordic_t               out_data
);

    logic             valid_reg;
    logic             valid_next;
    s2c_pkg::cordic_t data_reg;
    s2c_pkg::cordic_t data_next;
    s2c_pkg::data_t   x_sh;
    s2c_pkg::data_t   y_sh;
    s2c_pkg::res_t    atan_val;

    assign in_ready = !valid_reg || out_ready;
    assign x_sh     = in_data.x >>> step_idx;
    assign y_sh     = in_data.y >>> step_idx;
    assign atan_val = s2c_pkg::res_t'(s2c_pkg::atan_phase(step_idx));

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = in_data;
        // A non-negative residual rotates positively.
        if (!in_data.z[s2c_pkg::RES_W-1]) begin
            data_next.x = in_data.x - y_sh;
            data_next.y = in_data.y + x_sh;
            data_next.z = in_data.z - atan_val;
        end else begin
            data_next.x = in_data.x + y_sh;
            data_next.y = in_data.y - x_sh;
            data_next.z = in_data.z + atan_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/s2c_rotator.sv
// Full CORDIC rotation: quadrant fold, a chain of step cells, and unfold.
// Depends on s2c_pkg and s2c_cordic_cell.
module s2c_rotator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  s2c_pkg::data_t              mag,
    input  logic [s2c_pkg::FIELD_W-1:0] angle,
    input  s2c_pkg::data_t              aux_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output s2c_pkg::data_t              cos_out,
    output s2c_pkg::data_t              sin_out,
    output s2c_pkg::data_t              aux_out
);

    localparam int N = s2c_pkg::NUM_STEPS;
    localparam int EXT_W = s2c_pkg::FIELD_W + s2c_pkg::PHASE_W;

    logic [EXT_W-1:0]           angle_ext;
    logic [s2c_pkg::PHASE_W-1:0] phase;
    logic [s2c_pkg::PHASE_W-1:0] phase_fold;
    logic                       flip;

    logic             prep_valid_reg;
    s2c_pkg::cordic_t prep_reg;
    s2c_pkg::cordic_t prep_next;

    logic             chain_valid [0:N];
    logic             chain_ready [0:N];
    s2c_pkg::cordic_t chain_data  [0:N];

    logic             fin_valid_reg;
    s2c_pkg::data_t   fin_x_reg;
    s2c_pkg::data_t   fin_y_reg;
    s2c_pkg::data_t   fin_aux_reg;

    // Bits of the angle above ANGLE_BITS fall off the top of the phase word.
    assign angle_ext  = {{s2c_pkg::PHASE_W{1'b0}}, angle} << (s2c_pkg::PHASE_W - s2c_pkg::ANGLE_BITS);
    assign phase      = angle_ext[s2c_pkg::PHASE_W-1:0];
    assign flip       = phase[s2c_pkg::PHASE_W-1] ^ phase[s2c_pkg::PHASE_W-2];
    assign phase_fold = {phase[s2c_pkg::PHASE_W-1] ^ flip, phase[s2c_pkg::PHASE_W-2:0]};

    always_comb begin
        prep_next.x    = mag;
        prep_next.y    = '0;
        prep_next.z    = s2c_pkg::res_t'($signed(phase_fold));
        prep_next.flip = flip;
        prep_next.aux  = aux_in;
    end

    assign s_ready = !prep_valid_reg || chain_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (s_ready) begin
            prep_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            prep_reg <= prep_next;
        end
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_data[0]  = prep_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        s2c_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step_idx  (s2c_pkg::STEP_IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign chain_ready[N] = !fin_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (chain_ready[N]) begin
            fin_valid_reg <= chain_valid[N];
        end
        if (chain_valid[N] && chain_ready[N]) begin
            fin_x_reg   <= chain_data[N].flip ? -chain_data[N].x : chain_data[N].x;
            fin_y_reg   <= chain_data[N].flip ? -chain_data[N].y : chain_data[N].y;
            fin_aux_reg <= chain_data[N].aux;
        end
    end

    assign m_valid = fin_valid_reg;
    assign cos_out = fin_x_reg;
    assign sin_out = fin_y_reg;
    assign aux_out = fin_aux_reg;

endmodule

FILE: rtl/spherical_to_cartesian_unit.sv
// Top level of the spherical to Cartesian converter with stream ports.
// Depends on s2c_pkg and s2c_rotator (which uses s2c_cordic_cell).

// The unit accepts one (radius, azimuth, elevation) transfer per clock and
// returns one (x, up, z) transfer per clock, in order, while the output is
// not stalled. The pipeline is a gain multiply, an elevation rotation of
// NUM_STEPS cells plus fold and unfold, a second gain multiply, an azimuth
// rotation of the same length, and a rounding stage.
// Every stage has its own valid bit, so a stall at the output only fills up
// the empty stages and input keeps flowing until the pipeline is full.
module spherical_to_cartesian_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // radius[15:0], azimuth[31:16], elevation[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // x_comp[16:0], up_comp[33:17], z_comp[50:34], zero[55:51]
);

    localparam int FW = s2c_pkg::FIELD_W;

    logic [FW-1:0] radius;
    logic [FW-1:0] azimuth;
    logic [FW-1:0] elevation;

    // Stage A: radius times gain.
    logic                            a_valid_reg;
    logic                            a_ready;
    logic [s2c_pkg::RAD_PROD_W-1:0]  a_prod_reg;
    logic [FW-1:0]                   a_az_reg;
    logic [FW-1:0]                   a_el_reg;
    s2c_pkg::data_t                  el_mag;

    logic            r1_valid;
    logic            r1_ready;
    s2c_pkg::data_t  r1_cos;
    s2c_pkg::data_t  r1_sin;
    s2c_pkg::data_t  r1_aux;

    // Stage C: horizontal magnitude times gain.
    logic                                c_valid_reg;
    logic                                c_ready;
    logic signed [s2c_pkg::C_PROD_W-1:0] c_prod_reg;
    s2c_pkg::data_t                      c_up_reg;
    logic [FW-1:0]                       c_az_reg;
    s2c_pkg::data_t                      az_mag;

    logic            r2_valid;
    logic            r2_ready;
    s2c_pkg::data_t  r2_cos;
    s2c_pkg::data_t  r2_sin;
    s2c_pkg::data_t  r2_aux;

    // Output stage.
    logic                        d_valid_reg;
    logic [s2c_pkg::OUT_W-1:0]   d_x_reg;
    logic [s2c_pkg::OUT_W-1:0]   d_up_reg;
    logic [s2c_pkg::OUT_W-1:0]   d_z_reg;

    function automatic logic [s2c_pkg::OUT_W-1:0] round_sat(input s2c_pkg::data_t v);
        s2c_pkg::data_t                   t;
        logic signed [s2c_pkg::RND_W-1:0] r;
        t = v + s2c_pkg::data_t'(32768);
        r = t[s2c_pkg::DATA_W-1:16];
        if (r > s2c_pkg::OUT_MAX) begin
            r = s2c_pkg::OUT_MAX;
        end else if (r < -s2c_pkg::OUT_MAX) begin
            r = -s2c_pkg::OUT_MAX;
        end
        return r[s2c_pkg::OUT_W-1:0];
    endfunction

    assign radius    = s_tdata[15:0];
    assign azimuth   = s_tdata[31:16];
    assign elevation = s_tdata[47:32];

    assign s_tready = !a_valid_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            a_prod_reg <= s2c_pkg::RAD_PROD_W'(radius) * s2c_pkg::RAD_PROD_W'(s2c_pkg::GAIN_Q30);
            a_az_reg   <= azimuth;
            a_el_reg   <= elevation;
        end
    end

    // (r << 16) * K >> 30 is the product shifted right by 14.
    assign el_mag = s2c_pkg::data_t'(a_prod_reg[s2c_pkg::RAD_PROD_W-1:14]);

    s2c_rotator u_rot_el (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (a_valid_reg),
        .s_ready (a_ready),
        .mag     (el_mag),
        .angle   (a_el_reg),
        .aux_in  (s2c_pkg::data_t'(a_az_reg)),
        .m_valid (r1_valid),
        .m_ready (r1_ready),
        .cos_out (r1_cos),
        .sin_out (r1_sin),
        .aux_out (r1_aux)
    );

    assign r1_ready = !c_valid_reg || c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (r1_ready) begin
            c_valid_reg <= r1_valid;
        end
        if (r1_valid && r1_ready) begin
            c_prod_reg <= s2c_pkg::C_PROD_W'($signed(r1_cos[s2c_pkg::C_W-1:0]))
                        * s2c_pkg::C_PROD_W'($signed({1'b0, s2c_pkg::GAIN_Q30}));
            c_up_reg   <= r1_sin;
            c_az_reg   <= r1_aux[FW-1:0];
        end
    end

    // The horizontal magnitude is negative when the elevation points backward.
    assign az_mag = s2c_pkg::data_t'($signed(c_prod_reg[s2c_pkg::C_PROD_W-1:30]));

    s2c_rotator u_rot_az (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (c_valid_reg),
        .s_ready (c_ready),
        .mag     (az_mag),
        .angle   (c_az_reg),
        .aux_in  (c_up_reg),
        .m_valid (r2_valid),
        .m_ready (r2_ready),
        .cos_out (r2_cos),
        .sin_out (r2_sin),
        .aux_out (r2_aux)
    );

    assign r2_ready = !d_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (r2_ready) begin
            d_valid_reg <= r2_valid;
        end
        if (r2_valid && r2_ready) begin
            d_x_reg  <= round_sat(r2_cos);
            d_up_reg <= round_sat(r2_aux);
            d_z_reg  <= round_sat(r2_sin);
        end
    end

    assign m_tvalid = d_valid_reg;
    assign m_tdata  = {5'b0, d_z_reg, d_up_reg, d_x_reg};

endmodule
